// ===== rtl/chacha8_pkg.sv =====
// Shared types, constants and the quarter-round helper for the ChaCha8 stream cipher.
`default_nettype none

package chacha8_pkg;

    localparam int DEFAULT_ROUNDS = 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE     = 3'd4;

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    localparam logic [6:0] BLOCK_BYTES = 7'd64;

    typedef logic [15:0][31:0] blk_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROC,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_WAIT
    } fsm_state_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } qr_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int amt);
        return (v << amt) | (v >> (32 - amt));
    endfunction

    // half of a quarter round: two add/xor/rotate lines
    function automatic qr_t qr_half(input logic [31:0] a, input logic [31:0] b,
                                    input logic [31:0] c, input logic [31:0] d,
                                    input logic second);
        qr_t r;
        r.a = a + b;
        if (!second) begin
            r.d = rotl32(d ^ r.a, 16);
            r.c = c + r.d;
            r.b = rotl32(b ^ r.c, 12);
        end else begin
            r.d = rotl32(d ^ r.a, 8);
            r.c = c + r.d;
            r.b = rotl32(b ^ r.c, 7);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/chacha8_stream_cipher.sv =====
// Top level of the ChaCha8 stream cipher: sequencer, shared round unit and word channels.
// Usage
//   Input channel (s_valid/s_ready): one word carries up to eight message bytes,
//   byte zero in the low bits, a byte count and an end-of-call flag. Output channel
//   (m_valid/m_ready): the XORed bytes, bytes past the count zero, plus copies of
//   the count and the flag. Key and nonce are to be loaded through cfg_wr_en/
//   cfg_index/cfg_wdata only while no word is in flight, which the block itself
//   does not enforce; a nonce write restarts the block counter and ends any open call.
// Sequence
//   A word that finds keystream on hand is accepted, then XORed in a step that
//   also loads the output register. When the keystream runs dry the XOR state
//   first sees it, then the word passes a load state, the round state (column,
//   then diagonal step, each as two half quarter-rounds with the four lanes side
//   by side) and a feed-forward state; a word straddling two blocks gets a second XOR step.
// Reset
//   aresetn is synchronous, active low: key, nonce and counter go to zero, the
//   output is emptied and the next word starts a new call.
// Back-pressure
//   The result sits in the output register; the next word is accepted and
//   processed meanwhile, and its result waits inside until the register frees up.
`default_nettype none

module chacha8_stream_cipher #(
    parameter int ROUNDS = chacha8_pkg::DEFAULT_ROUNDS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [chacha8_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                       cfg_wdata,
    // input words
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [63:0]                       s_data_in,
    input  wire logic [3:0]                        s_byte_count,
    input  wire logic                              s_end_of_call,
    // result words
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [63:0]                            m_data_out,
    output logic [3:0]                             m_bytes_valid,
    output logic                                   m_last_of_call
);

    // double rounds; an odd count runs one extra full double round
    localparam int DOUBLE_ROUNDS = (ROUNDS + 1) / 2;
    localparam int STEPS         = 4 * DOUBLE_ROUNDS;   // half quarter-round steps
    localparam int STEP_W        = $clog2(STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    // config registers
    logic [3:0][63:0] key_reg;
    logic [63:0]      nonce_reg;

    // control state
    chacha8_pkg::fsm_state_t state_reg, state_next;
    logic [63:0]       counter_reg, counter_next;
    logic [6:0]        avail_reg, avail_next;     // keystream bytes left in blk_reg
    logic              inside_reg, inside_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;

    // working block: round state, then the keystream, consumed from the bottom
    chacha8_pkg::blk_t blk_reg, blk_next;

    // current word
    logic [63:0] data_reg, data_next;
    logic [3:0]  count_reg, count_next;
    logic        last_reg, last_next;
    logic [3:0]  k_reg, k_next;                   // bytes of this word done
    logic [63:0] res_reg, res_next;

    // output register
    logic [63:0] m_data_reg, m_data_next;
    logic [3:0]  m_count_reg, m_count_next;
    logic        m_last_reg, m_last_next;

    chacha8_pkg::blk_t init_blk;
    chacha8_pkg::blk_t round_blk;

    logic [3:0]  cnt_eff;
    logic [3:0]  left;
    logic [3:0]  n_use;
    logic        word_done;
    logic        out_free;
    logic [63:0] ks_sh;
    logic [63:0] byte_mask;
    logic [63:0] res_comb;
    logic        nonce_wr;

    assign nonce_wr = cfg_wr_en && (cfg_index == chacha8_pkg::CFG_NONCE);

    // block input: constant, key, counter, nonce
    always_comb begin
        init_blk[0]  = chacha8_pkg::SIGMA_0;
        init_blk[1]  = chacha8_pkg::SIGMA_1;
        init_blk[2]  = chacha8_pkg::SIGMA_2;
        init_blk[3]  = chacha8_pkg::SIGMA_3;
        for (int i = 0; i < 4; i++) begin
            init_blk[4 + 2 * i] = key_reg[i][31:0];
            init_blk[5 + 2 * i] = key_reg[i][63:32];
        end
        init_blk[12] = counter_reg[31:0];
        init_blk[13] = counter_reg[63:32];
        init_blk[14] = nonce_reg[31:0];
        init_blk[15] = nonce_reg[63:32];
    end

    // shared round unit: four lanes, column or diagonal by step bit 1,
    // first or second half of the quarter round by step bit 0
    always_comb begin
        logic [3:0]        ia, ib, ic, id;
        logic              diag;
        chacha8_pkg::qr_t  qr;
        diag      = step_reg[1];
        round_blk = blk_reg;
        for (int i = 0; i < 4; i++) begin
            ia = {2'b00, 2'(i)};
            ib = {2'b01, 2'(i) + {1'b0, diag}};
            ic = {2'b10, 2'(i) + {diag, 1'b0}};
            id = {2'b11, 2'(i) + {diag, diag}};
            qr = chacha8_pkg::qr_half(blk_reg[ia], blk_reg[ib], blk_reg[ic], blk_reg[id],
                                      step_reg[0]);
            round_blk[ia] = qr.a;
            round_blk[ib] = qr.b;
            round_blk[ic] = qr.c;
            round_blk[id] = qr.d;
        end
    end

    // byte bookkeeping for the XOR step
    assign cnt_eff   = (count_reg > 4'd8) ? 4'd8 : count_reg;
    assign left      = cnt_eff - k_reg;
    assign n_use     = (avail_reg < {3'b000, left}) ? avail_reg[3:0] : left;
    assign word_done = ((k_reg + n_use) == cnt_eff);
    assign out_free  = !m_valid_reg || m_ready;
    assign ks_sh     = 64'(blk_reg[1:0]) << {k_reg, 3'b000};

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            byte_mask[8 * j +: 8] = ((4'(j) >= k_reg) && (4'(j) < (k_reg + n_use)))
                                    ? 8'hff : 8'h00;
        end
    end

    assign res_comb = res_reg | ((data_reg ^ ks_sh) & byte_mask);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        counter_next = counter_reg;
        avail_next   = avail_reg;
        inside_next  = inside_reg;
        step_next    = step_reg;
        blk_next     = blk_reg;
        data_next    = data_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        k_next       = k_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_count_next = m_count_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;

        unique case (state_reg)
            chacha8_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    data_next   = s_data_in;
                    count_next  = s_byte_count;
                    last_next   = s_end_of_call;
                    k_next      = 4'd0;
                    res_next    = 64'd0;
                    inside_next = !s_end_of_call;
                    if (!inside_reg) begin
                        avail_next = 7'd0;      // new call: fresh block on first byte
                    end
                    state_next  = chacha8_pkg::ST_PROC;
                end
            end
            chacha8_pkg::ST_PROC: begin
                if (avail_reg == 7'd0 && left != 4'd0) begin
                    state_next = chacha8_pkg::ST_LOAD;
                end else begin
                    res_next   = res_comb;
                    k_next     = k_reg + n_use;
                    avail_next = avail_reg - {3'b000, n_use};
                    blk_next   = blk_reg >> {n_use, 3'b000};
                    if (word_done) begin
                        if (out_free) begin
                            m_data_next  = res_comb;
                            m_count_next = count_reg;
                            m_last_next  = last_reg;
                            m_valid_next = 1'b1;
                            state_next   = chacha8_pkg::ST_IDLE;
                        end else begin
                            state_next = chacha8_pkg::ST_WAIT;
                        end
                    end
                end
            end
            chacha8_pkg::ST_LOAD: begin
                blk_next   = init_blk;
                step_next  = '0;
                state_next = chacha8_pkg::ST_ROUND;
            end
            chacha8_pkg::ST_ROUND: begin
                blk_next  = round_blk;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = chacha8_pkg::ST_FINAL;
                end
            end
            chacha8_pkg::ST_FINAL: begin
                for (int i = 0; i < 16; i++) begin
                    blk_next[i] = blk_reg[i] + init_blk[i];
                end
                counter_next = counter_reg + 64'd1;
                avail_next   = chacha8_pkg::BLOCK_BYTES;
                state_next   = chacha8_pkg::ST_PROC;
            end
            chacha8_pkg::ST_WAIT: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_count_next = count_reg;
                    m_last_next  = last_reg;
                    m_valid_next = 1'b1;
                    state_next   = chacha8_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = chacha8_pkg::ST_IDLE;
            end
        endcase

        // nonce write restarts the counter and closes any open call
        if (nonce_wr) begin
            counter_next = 64'd0;
            inside_next  = 1'b0;
            avail_next   = 7'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chacha8_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= 64'd0;
            avail_reg   <= 7'd0;
            inside_reg  <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            counter_reg <= counter_next;
            avail_reg   <= avail_next;
            inside_reg  <= inside_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            nonce_reg <= 64'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                chacha8_pkg::CFG_KEY_0_7:   key_reg[0] <= cfg_wdata;
                chacha8_pkg::CFG_KEY_8_15:  key_reg[1] <= cfg_wdata;
                chacha8_pkg::CFG_KEY_16_23: key_reg[2] <= cfg_wdata;
                chacha8_pkg::CFG_KEY_24_31: key_reg[3] <= cfg_wdata;
                chacha8_pkg::CFG_NONCE:     nonce_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        blk_reg     <= blk_next;
        data_reg    <= data_next;
        count_reg   <= count_next;
        last_reg    <= last_next;
        k_reg       <= k_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
        m_count_reg <= m_count_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_data_out     = m_data_reg;
    assign m_bytes_valid  = m_count_reg;
    assign m_last_of_call = m_last_reg;

    // checks
    a_avail_range: assert property (@(posedge aclk) disable iff (!aresetn)
        avail_reg <= chacha8_pkg::BLOCK_BYTES)
        else $error("keystream byte count above one block");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == chacha8_pkg::ST_ROUND) |-> (step_reg <= LAST_STEP))
        else $error("round step past last");

    a_block_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == chacha8_pkg::ST_FINAL && !nonce_wr) |=>
            (avail_reg == chacha8_pkg::BLOCK_BYTES &&
             counter_reg == $past(counter_reg) + 64'd1))
        else $error("finished block did not refill keystream and bump counter");

    a_bytes_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == chacha8_pkg::ST_PROC || state_reg == chacha8_pkg::ST_WAIT)
            |-> (k_reg <= cnt_eff))
        else $error("more bytes processed than the word holds");

endmodule

`default_nettype wire

// ===== bench/chacha8_stream_cipher_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the ChaCha8 stream cipher: keystream predictor, scoreboard and traffic.
module chacha8_stream_cipher_tb;

    // Bench sizing. SETTLE_CYCLES covers one full block build (load, rounds,
    // feed-forward) plus the XOR and output register stages, with margin.
    localparam int ROUNDS          = chacha8_pkg::DEFAULT_ROUNDS;
    localparam int SETTLE_CYCLES   = 4 * ((ROUNDS + 1) / 2) + 14;
    localparam int WORDS_PER_PHASE = 90;
    localparam int NUM_PHASES      = 5;
    localparam int WORD_BYTES      = 8;
    localparam int BLOCK_LEN       = 64;
    // index with no register behind it; the block must ignore writes to it
    localparam logic [chacha8_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    // one word on either channel
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
    } cipher_word_t;

    // Predicts ciphertext words from accepted plaintext words and checks the
    // words leaving the block against them, oldest first.
    class chacha_xor_scoreboard;
        logic [63:0]  key_words [4];
        logic [63:0]  nonce;
        logic [63:0]  blk_ctr;
        logic [31:0]  ks_words [16];
        logic [31:0]  mix [16];
        int unsigned  pos;
        bit           in_call;
        cipher_word_t pending_ciphertext [$];
        int unsigned  mismatches;
        int unsigned  words_checked;

        function void clear_state();
            for (int i = 0; i < 4; i++) key_words[i] = '0;
            for (int i = 0; i < 16; i++) ks_words[i] = '0;
            nonce         = '0;
            blk_ctr       = '0;
            pos           = 0;
            in_call       = 1'b0;
            mismatches    = 0;
            words_checked = 0;
            pending_ciphertext.delete();
        endfunction

        function logic [31:0] rol(logic [31:0] v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void quarter(int a, int b, int c, int d);
            mix[a] = mix[a] + mix[b]; mix[d] = rol(mix[d] ^ mix[a], 16);
            mix[c] = mix[c] + mix[d]; mix[b] = rol(mix[b] ^ mix[c], 12);
            mix[a] = mix[a] + mix[b]; mix[d] = rol(mix[d] ^ mix[a], 8);
            mix[c] = mix[c] + mix[d]; mix[b] = rol(mix[b] ^ mix[c], 7);
        endfunction

        // builds the next 64-byte keystream block and bumps the counter
        function void make_keystream_block();
            logic [31:0] init [16];
            init[0] = chacha8_pkg::SIGMA_0;
            init[1] = chacha8_pkg::SIGMA_1;
            init[2] = chacha8_pkg::SIGMA_2;
            init[3] = chacha8_pkg::SIGMA_3;
            for (int i = 0; i < 4; i++) begin
                init[4 + 2 * i] = key_words[i][31:0];
                init[5 + 2 * i] = key_words[i][63:32];
            end
            init[12] = blk_ctr[31:0];
            init[13] = blk_ctr[63:32];
            init[14] = nonce[31:0];
            init[15] = nonce[63:32];
            for (int i = 0; i < 16; i++) mix[i] = init[i];
            // odd round counts get a full extra double round
            for (int r = ROUNDS; r > 0; r -= 2) begin
                quarter(0, 4, 8, 12);
                quarter(1, 5, 9, 13);
                quarter(2, 6, 10, 14);
                quarter(3, 7, 11, 15);
                quarter(0, 5, 10, 15);
                quarter(1, 6, 11, 12);
                quarter(2, 7, 8, 13);
                quarter(3, 4, 9, 14);
            end
            for (int i = 0; i < 16; i++) ks_words[i] = mix[i] + init[i];
            blk_ctr = blk_ctr + 64'd1;
        endfunction

        function void write_reg(logic [chacha8_pkg::CFG_IDX_W-1:0] idx, logic [63:0] v);
            case (idx)
                chacha8_pkg::CFG_KEY_0_7:   key_words[0] = v;
                chacha8_pkg::CFG_KEY_8_15:  key_words[1] = v;
                chacha8_pkg::CFG_KEY_16_23: key_words[2] = v;
                chacha8_pkg::CFG_KEY_24_31: key_words[3] = v;
                chacha8_pkg::CFG_NONCE: begin
                    nonce   = v;
                    blk_ctr = '0;
                    in_call = 1'b0;
                    pos     = 0;
                end
                default: ;
            endcase
        endfunction

        function void take_plaintext(logic [63:0] d, logic [3:0] c, logic l);
            cipher_word_t w;
            int unsigned  used;
            logic [31:0]  kw;
            used = (c > WORD_BYTES) ? WORD_BYTES : c;
            if (!in_call) begin
                in_call = 1'b1;
                pos     = 0;
            end
            w.data  = '0;
            w.count = c;
            w.last  = l;
            for (int k = 0; k < used; k++) begin
                if (pos == 0) make_keystream_block();
                kw = ks_words[pos >> 2] >> (8 * (pos & 3));
                w.data[8 * k +: 8] = d[8 * k +: 8] ^ kw[7:0];
                pos = (pos + 1) % BLOCK_LEN;
            end
            if (l) in_call = 1'b0;
            pending_ciphertext.push_back(w);
        endfunction

        function void check_ciphertext(logic [63:0] d, logic [3:0] c, logic l);
            cipher_word_t exp_w;
            if (pending_ciphertext.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing pending: data %h count %0d last %0b",
                         $time, d, c, l);
                return;
            end
            exp_w = pending_ciphertext.pop_front();
            words_checked++;
            if (exp_w.data !== d) begin
                mismatches++;
                $display("%0t: data_out mismatch: expected %h, got %h", $time, exp_w.data, d);
            end
            if (exp_w.count !== c) begin
                mismatches++;
                $display("%0t: bytes_valid mismatch: expected %0d, got %0d",
                         $time, exp_w.count, c);
            end
            if (exp_w.last !== l) begin
                mismatches++;
                $display("%0t: last_of_call mismatch: expected %0b, got %0b",
                         $time, exp_w.last, l);
            end
        endfunction
    endclass

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // configuration port
    logic                              cfg_wr_en = 1'b0;
    logic [chacha8_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]                       cfg_wdata = '0;

    // plaintext words in
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [63:0] s_data_in     = '0;
    logic [3:0]  s_byte_count  = '0;
    logic        s_end_of_call = 1'b0;

    // ciphertext words out
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_data_out;
    logic [3:0]  m_bytes_valid;
    logic        m_last_of_call;

    // idle percentages of the current phase
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned words_sent     = 0;

    chacha_xor_scoreboard sb;

    chacha8_stream_cipher #(
        .ROUNDS(ROUNDS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_in     (s_data_in),
        .s_byte_count  (s_byte_count),
        .s_end_of_call (s_end_of_call),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_out    (m_data_out),
        .m_bytes_valid (m_bytes_valid),
        .m_last_of_call(m_last_of_call)
    );

    // 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Output side: check the word taken at this edge (pre-edge values), then
    // choose whether to stall the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_ciphertext(m_data_out, m_bytes_valid, m_last_of_call);
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offers one plaintext word and returns at the edge that takes it. Valid is
    // only dropped while idling, so back-to-back words keep it high.
    task automatic push_word(input logic [63:0] d, input logic [3:0] c, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_in     <= d;
        s_byte_count  <= c;
        s_end_of_call <= l;
        do @(posedge aclk); while (!s_ready);
        sb.take_plaintext(d, c, l);
        words_sent++;
    endtask

    // Let every pending ciphertext word come out, then give the round unit
    // time to finish so a register write lands on an idle block.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending_ciphertext.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; leaves the enable high so writes can run back to back.
    task automatic cfg_write(input logic [chacha8_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.write_reg(idx, v);
    endtask

    initial begin
        int unsigned left_in_call;
        logic [3:0]  cnt;
        logic        lst;

        sb = new;
        sb.clear_state();
        left_in_call = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset key and nonce (all zero).
        // Plain call ending on a short word, extreme data patterns.
        push_word(64'h0, 4'd8, 1'b0);
        push_word('1, 4'd8, 1'b0);
        push_word(64'h0123_4567_89ab_cdef, 4'd3, 1'b1);
        // one-byte call
        push_word('1, 4'd1, 1'b1);
        // empty call: no block made, counter must not move
        push_word('1, 4'd0, 1'b1);
        // count field above eight, acts as eight
        push_word(rand64(), 4'd15, 1'b1);
        // short word first, then keystream runs across the 64-byte boundary
        push_word(rand64(), 4'd5, 1'b0);
        repeat (8) push_word(rand64(), 4'd8, 1'b0);
        push_word(rand64(), 4'd9, 1'b0);
        // zero count in the middle of a call
        push_word(rand64(), 4'd0, 1'b0);
        push_word(rand64(), 4'd2, 1'b1);
        // left open so the first key change lands inside a call
        push_word(rand64(), 4'd8, 1'b0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    // all-ones key mid-call: current block kept, new key next block
                    cfg_write(chacha8_pkg::CFG_KEY_0_7,   '1);
                    cfg_write(chacha8_pkg::CFG_KEY_8_15,  '1);
                    cfg_write(chacha8_pkg::CFG_KEY_16_23, '1);
                    cfg_write(chacha8_pkg::CFG_KEY_24_31, '1);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    cfg_write(chacha8_pkg::CFG_KEY_0_7,   rand64());
                    cfg_write(chacha8_pkg::CFG_KEY_8_15,  rand64());
                    cfg_write(chacha8_pkg::CFG_KEY_16_23, rand64());
                    cfg_write(chacha8_pkg::CFG_KEY_24_31, rand64());
                    cfg_write(chacha8_pkg::CFG_NONCE,     '1);
                    send_idle_pct  = 49;
                    recv_stall_pct = 0;
                end
                2: begin
                    // single key word, call may still be open
                    cfg_write(chacha8_pkg::CFG_KEY_8_15, rand64());
                    send_idle_pct  = 0;
                    recv_stall_pct = 49;
                end
                3: begin
                    cfg_write(chacha8_pkg::CFG_KEY_0_7,   rand64());
                    cfg_write(chacha8_pkg::CFG_KEY_8_15,  rand64());
                    cfg_write(chacha8_pkg::CFG_KEY_16_23, rand64());
                    cfg_write(chacha8_pkg::CFG_KEY_24_31, rand64());
                    cfg_write(chacha8_pkg::CFG_NONCE,     rand64());
                    cfg_write(CFG_UNMAPPED,               rand64());
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
                default: begin
                    // back to an all-zero key and nonce
                    cfg_write(chacha8_pkg::CFG_KEY_0_7,   '0);
                    cfg_write(chacha8_pkg::CFG_KEY_8_15,  '0);
                    cfg_write(chacha8_pkg::CFG_KEY_16_23, '0);
                    cfg_write(chacha8_pkg::CFG_KEY_24_31, '0);
                    cfg_write(chacha8_pkg::CFG_NONCE,     '0);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            cfg_wr_en <= 1'b0;

            // Mostly well-formed calls: full words, short last word; some are
            // long enough to need several blocks. A few words carry any
            // 4-bit count, sometimes with the end flag flipped.
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (left_in_call == 0)
                    left_in_call = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                               : $urandom_range(1, 8);
                lst = (left_in_call == 1);
                left_in_call--;
                if ($urandom_range(0, 99) < 12) begin
                    cnt = 4'($urandom_range(0, 15));
                    if ($urandom_range(0, 3) == 0) lst = ~lst;
                end else begin
                    cnt = lst ? 4'($urandom_range(1, WORD_BYTES)) : 4'(WORD_BYTES);
                end
                push_word(rand64(), cnt, lst);
            end
        end

        wait_idle();
        $display("Sent %0d words over %0d phases of key/nonce settings and idle patterns;",
                 words_sent, NUM_PHASES);
        $display("checked %0d ciphertext words, %0d mismatches.",
                 sb.words_checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
